// ----- hw/rtl/vfre_pkg.sv -----
// shared widths, command and register codes, and state encoding for the ripple engine
package vfre_pkg;

    localparam int CMD_BITS      = 3;
    localparam int IDX_BITS      = 12;
    localparam int VAL_BITS      = 16;
    localparam int FACTOR_BITS   = 9;
    localparam int GRID_BITS     = 7;
    localparam int REG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 9;

    localparam logic [CMD_BITS-1:0] CMD_WRITE = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_READ  = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_STEP  = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_FADE  = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 3'd4;

    localparam logic [REG_IDX_BITS-1:0] REG_COLS    = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_ROWS    = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_DAMPING = 2'd2;

    localparam logic [GRID_BITS-1:0]   COLS_RESET    = 7'd64;
    localparam logic [GRID_BITS-1:0]   ROWS_RESET    = 7'd64;
    localparam logic [FACTOR_BITS-1:0] DAMPING_RESET = 9'd230;
    localparam logic [FACTOR_BITS-1:0] FACTOR_ONE    = 9'd256;
    localparam logic [GRID_BITS-1:0]   GRID_MIN      = 7'd3;

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_STEP  = 7'b0001000,
        S_FADE  = 7'b0010000,
        S_CLEAR = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

endpackage

// ----- hw/rtl/vfre_ifs.sv -----
// handshake channels: command in, result out, register write
interface vfre_cmd_if;
    import vfre_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [CMD_BITS-1:0]        command;
    logic [IDX_BITS-1:0]        cell_index;
    logic signed [VAL_BITS-1:0] value_x;
    logic signed [VAL_BITS-1:0] value_y;
    logic [FACTOR_BITS-1:0]     fade_factor;
    modport source (output valid, command, cell_index, value_x, value_y, fade_factor,
                    input ready);
    modport sink   (input valid, command, cell_index, value_x, value_y, fade_factor,
                    output ready);
endinterface

interface vfre_res_if;
    import vfre_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [VAL_BITS-1:0] read_x;
    logic signed [VAL_BITS-1:0] read_y;
    logic                       status;
    modport source (output valid, read_x, read_y, status, input ready);
    modport sink   (input valid, read_x, read_y, status, output ready);
endinterface

interface vfre_cfg_if;
    import vfre_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [REG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/vfre_page_ram.sv -----
// one page of cells: single write port, single read port, registered read data
module vfre_page_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/vector_field_ripple_engine.sv -----
// ripple engine top: sequencer over two page memories
//
//  channel  dir  modport  payload
//  i_cmd    in   sink     command, cell_index, value_x, value_y, fade_factor
//  o_res    out  source   read_x, read_y, status
//  i_cfg    in   sink     index, data (cols_in_use, rows_in_use, damping)
//
// a write is done as it is accepted, a read fetches its cell, clear zeroes cols*rows cells,
// fade reads, multiplies and writes back each cell on the single page read port,
// step per inner cell: four neighbor reads through the current page port,
// then sum, multiply, write. each command then passes through the output load state.
// after reset a clearing pass over all MAX_COLS*MAX_ROWS cells zeroes both pages;
// commands wait for it, register writes are taken at any time.
// a held result does not stop the next command being taken and run; only its output load waits.
module vector_field_ripple_engine #(
    parameter int MAX_COLS       = 64,
    parameter int MAX_ROWS       = 64,
    parameter int COMPONENT_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vfre_cmd_if.sink   i_cmd,
    vfre_res_if.source o_res,
    vfre_cfg_if.sink   i_cfg
);
    import vfre_pkg::*;

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CB    = COMPONENT_BITS;
    localparam int SW    = CB + 2;
    localparam int WW    = CB + 12;

    localparam logic signed [WW-1:0] SAT_HI = WW'((64'sd1 <<< (CB - 1)) - 64'sd1);
    localparam logic signed [WW-1:0] SAT_LO = ~SAT_HI;

    localparam logic [2:0] PH_RD_W = 3'd0;
    localparam logic [2:0] PH_RD_E = 3'd1;
    localparam logic [2:0] PH_RD_N = 3'd2;
    localparam logic [2:0] PH_RD_S = 3'd3;
    localparam logic [2:0] PH_SUM  = 3'd4;
    localparam logic [2:0] PH_MUL  = 3'd5;
    localparam logic [2:0] PH_WR   = 3'd6;
    localparam logic [2:0] FD_RD   = 3'd0;
    localparam logic [2:0] FD_MUL  = 3'd1;
    localparam logic [2:0] FD_WR   = 3'd2;

    function automatic logic [CB-1:0] sat_c(input logic signed [WW-1:0] v);
        if (v > SAT_HI) begin
            sat_c = SAT_HI[CB-1:0];
        end else if (v < SAT_LO) begin
            sat_c = SAT_LO[CB-1:0];
        end else begin
            sat_c = v[CB-1:0];
        end
    endfunction

    t_state r_state, n_state;

    logic [GRID_BITS-1:0]   r_cols_cfg, r_rows_cfg;
    logic [FACTOR_BITS-1:0] r_damp_cfg;
    logic                   r_cur;
    logic [AW-1:0]          r_pos;
    logic [GRID_BITS-1:0]   r_col, r_row;
    logic [2:0]             r_ph;
    logic signed [9:0]      r_fade;
    logic signed [SW-1:0]   r_acc_x, r_acc_y;
    logic signed [CB-1:0]   r_nxt_x, r_nxt_y;
    logic signed [WW-1:0]   r_prod_x, r_prod_y;
    logic [VAL_BITS-1:0]    r_res_x, r_res_y;
    logic                   r_res_st;
    logic [VAL_BITS-1:0]    r_out_x, r_out_y;
    logic                   r_out_st;
    logic                   r_ov;

    logic [GRID_BITS-1:0]   cols_c, rows_c;
    logic [2*GRID_BITS-1:0] total;
    logic signed [9:0]      damp_c, fade_c;
    logic [AW-1:0]          cols_a, idx_a, a_m1, a_p1, a_mc, a_pc;
    logic                   in_xfer, in_range, lin_last, grid_last, row_end, out_load;

    logic                   cur_we, nxt_we;
    logic [AW-1:0]          cur_waddr, cur_raddr, nxt_waddr, nxt_raddr;
    logic [2*CB-1:0]        cur_wdata, nxt_wdata, cur_rdata, nxt_rdata;
    logic                   m0_we, m1_we;
    logic [AW-1:0]          m0_waddr, m0_raddr, m1_waddr, m1_raddr;
    logic [2*CB-1:0]        m0_wdata, m1_wdata, m0_rdata, m1_rdata;
    logic signed [CB-1:0]   cur_rd_x, cur_rd_y;
    logic signed [WW-1:0]   rd_ext_x, rd_ext_y;
    logic signed [SW-1:0]   ex_x, ex_y;

    // grid size and factors as they act
    always_comb begin
        if (r_cols_cfg < GRID_MIN) begin
            cols_c = GRID_MIN;
        end else if (32'(r_cols_cfg) > MAX_COLS) begin
            cols_c = GRID_BITS'(MAX_COLS);
        end else begin
            cols_c = r_cols_cfg;
        end
        if (r_rows_cfg < GRID_MIN) begin
            rows_c = GRID_MIN;
        end else if (32'(r_rows_cfg) > MAX_ROWS) begin
            rows_c = GRID_BITS'(MAX_ROWS);
        end else begin
            rows_c = r_rows_cfg;
        end
        damp_c = (r_damp_cfg > FACTOR_ONE) ? 10'sd256 : $signed({1'b0, r_damp_cfg});
        fade_c = (i_cmd.fade_factor > FACTOR_ONE) ? 10'sd256
                                                  : $signed({1'b0, i_cmd.fade_factor});
    end

    assign total     = (2*GRID_BITS)'(cols_c) * (2*GRID_BITS)'(rows_c);
    assign cols_a    = AW'(cols_c);
    assign idx_a     = AW'(i_cmd.cell_index);
    assign a_m1      = r_pos - AW'(1);
    assign a_p1      = r_pos + AW'(1);
    assign a_mc      = r_pos - cols_a;
    assign a_pc      = r_pos + cols_a;
    assign in_xfer   = i_cmd.valid && i_cmd.ready;
    assign in_range  = (2*GRID_BITS+1)'(i_cmd.cell_index) < (2*GRID_BITS+1)'(total);
    assign lin_last  = (32'(r_pos) + 32'd1) == 32'(total);
    assign row_end   = r_col == (cols_c - GRID_BITS'(2));
    assign grid_last = row_end && (r_row == (rows_c - GRID_BITS'(2)));
    assign out_load  = (r_state == S_OUT) && (!r_ov || o_res.ready);

    assign cur_rd_x = $signed(cur_rdata[2*CB-1:CB]);
    assign cur_rd_y = $signed(cur_rdata[CB-1:0]);
    assign rd_ext_x = WW'(cur_rd_x);
    assign rd_ext_y = WW'(cur_rd_y);
    assign ex_x     = (r_acc_x >>> 1) - SW'(r_nxt_x);
    assign ex_y     = (r_acc_y >>> 1) - SW'(r_nxt_y);

    assign i_cmd.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid  = r_ov;
    assign o_res.read_x = $signed(r_out_x);
    assign o_res.read_y = $signed(r_out_y);
    assign o_res.status = r_out_st;

    // page port control in terms of current and next page
    always_comb begin
        cur_we    = 1'b0;
        cur_waddr = r_pos;
        cur_wdata = '0;
        cur_raddr = r_pos;
        nxt_we    = 1'b0;
        nxt_waddr = r_pos;
        nxt_wdata = '0;
        nxt_raddr = r_pos;
        unique case (r_state)
            S_INIT: begin
                cur_we = 1'b1;
                nxt_we = 1'b1;
            end
            S_IDLE: begin
                cur_raddr = idx_a;
                cur_waddr = idx_a;
                cur_wdata = {sat_c(WW'(i_cmd.value_x)), sat_c(WW'(i_cmd.value_y))};
                cur_we    = in_xfer && (i_cmd.command == CMD_WRITE) && in_range;
            end
            S_STEP: begin
                case (r_ph)
                    PH_RD_W: cur_raddr = a_m1;
                    PH_RD_E: cur_raddr = a_p1;
                    PH_RD_N: cur_raddr = a_mc;
                    PH_RD_S: cur_raddr = a_pc;
                    default: cur_raddr = r_pos;
                endcase
                nxt_we    = (r_ph == PH_WR);
                nxt_wdata = {sat_c(r_prod_x >>> 8), sat_c(r_prod_y >>> 8)};
            end
            S_FADE: begin
                cur_we    = (r_ph == FD_WR);
                cur_wdata = {sat_c(r_prod_x >>> 8), sat_c(r_prod_y >>> 8)};
            end
            S_CLEAR: begin
                cur_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // map roles onto the two physical pages
    always_comb begin
        m0_we    = r_cur ? nxt_we    : cur_we;
        m0_waddr = r_cur ? nxt_waddr : cur_waddr;
        m0_wdata = r_cur ? nxt_wdata : cur_wdata;
        m0_raddr = r_cur ? nxt_raddr : cur_raddr;
        m1_we    = r_cur ? cur_we    : nxt_we;
        m1_waddr = r_cur ? cur_waddr : nxt_waddr;
        m1_wdata = r_cur ? cur_wdata : nxt_wdata;
        m1_raddr = r_cur ? cur_raddr : nxt_raddr;
        cur_rdata = r_cur ? m1_rdata : m0_rdata;
        nxt_rdata = r_cur ? m0_rdata : m1_rdata;
    end

    vfre_page_ram #(.DEPTH(DEPTH), .WIDTH(2*CB)) u_page0 (
        .i_clk   (i_clk),
        .i_we    (m0_we),
        .i_waddr (m0_waddr),
        .i_wdata (m0_wdata),
        .i_raddr (m0_raddr),
        .o_rdata (m0_rdata)
    );

    vfre_page_ram #(.DEPTH(DEPTH), .WIDTH(2*CB)) u_page1 (
        .i_clk   (i_clk),
        .i_we    (m1_we),
        .i_waddr (m1_waddr),
        .i_wdata (m1_wdata),
        .i_raddr (m1_raddr),
        .o_rdata (m1_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (32'(r_pos) == DEPTH - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_cmd.command)
                        CMD_READ:  n_state = in_range ? S_READ : S_OUT;
                        CMD_STEP:  n_state = S_STEP;
                        CMD_FADE:  n_state = S_FADE;
                        CMD_CLEAR: n_state = S_CLEAR;
                        default:   n_state = S_OUT;
                    endcase
                end
            end
            S_READ:  n_state = S_OUT;
            S_STEP:  n_state = (r_ph == PH_WR && grid_last) ? S_OUT : S_STEP;
            S_FADE:  n_state = (r_ph == FD_WR && lin_last) ? S_OUT : S_FADE;
            S_CLEAR: n_state = lin_last ? S_OUT : S_CLEAR;
            S_OUT:   n_state = out_load ? S_IDLE : S_OUT;
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_cols_cfg <= COLS_RESET;
            r_rows_cfg <= ROWS_RESET;
            r_damp_cfg <= DAMPING_RESET;
            r_cur      <= 1'b0;
            r_pos      <= '0;
            r_ph       <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_COLS:    r_cols_cfg <= i_cfg.data[GRID_BITS-1:0];
                    REG_ROWS:    r_rows_cfg <= i_cfg.data[GRID_BITS-1:0];
                    REG_DAMPING: r_damp_cfg <= i_cfg.data;
                    default: begin
                    end
                endcase
            end

            if (out_load) begin
                r_ov     <= 1'b1;
                r_out_x  <= r_res_x;
                r_out_y  <= r_res_y;
                r_out_st <= r_res_st;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_INIT: begin
                    r_pos <= (32'(r_pos) == DEPTH - 1) ? '0 : r_pos + AW'(1);
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_res_x  <= '0;
                        r_res_y  <= '0;
                        r_res_st <= (i_cmd.command inside {CMD_WRITE, CMD_READ}) && !in_range;
                        r_pos    <= (i_cmd.command == CMD_STEP) ? cols_a + AW'(1) : '0;
                        r_ph     <= '0;
                        r_fade   <= fade_c;
                        r_col    <= GRID_BITS'(1);
                        r_row    <= GRID_BITS'(1);
                    end
                end
                S_READ: begin
                    r_res_x <= rd_ext_x[VAL_BITS-1:0];
                    r_res_y <= rd_ext_y[VAL_BITS-1:0];
                end
                S_STEP: begin
                    r_ph <= (r_ph == PH_WR) ? PH_RD_W : r_ph + 3'd1;
                    case (r_ph)
                        PH_RD_E: begin
                            r_acc_x <= SW'(cur_rd_x);
                            r_acc_y <= SW'(cur_rd_y);
                            r_nxt_x <= $signed(nxt_rdata[2*CB-1:CB]);
                            r_nxt_y <= $signed(nxt_rdata[CB-1:0]);
                        end
                        PH_RD_N, PH_RD_S, PH_SUM: begin
                            r_acc_x <= r_acc_x + SW'(cur_rd_x);
                            r_acc_y <= r_acc_y + SW'(cur_rd_y);
                        end
                        PH_MUL: begin
                            r_prod_x <= WW'(ex_x) * WW'(damp_c);
                            r_prod_y <= WW'(ex_y) * WW'(damp_c);
                        end
                        PH_WR: begin
                            if (grid_last) begin
                                r_cur <= ~r_cur;
                            end else if (row_end) begin
                                r_col <= GRID_BITS'(1);
                                r_row <= r_row + GRID_BITS'(1);
                                r_pos <= r_pos + AW'(3);
                            end else begin
                                r_col <= r_col + GRID_BITS'(1);
                                r_pos <= r_pos + AW'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_FADE: begin
                    r_ph <= (r_ph == FD_WR) ? FD_RD : r_ph + 3'd1;
                    if (r_ph == FD_MUL) begin
                        r_prod_x <= rd_ext_x * WW'(r_fade);
                        r_prod_y <= rd_ext_y * WW'(r_fade);
                    end
                    if (r_ph == FD_WR) begin
                        r_pos <= r_pos + AW'(1);
                    end
                end
                S_CLEAR: begin
                    r_pos <= r_pos + AW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // pages swap only at the last write of a step
    a_flip_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur != $past(r_cur)) |-> ($past(r_state) == S_STEP && $past(r_ph) == PH_WR))
        else $error("page swap outside the end of a step");

    // outside the clearing pass the two pages are never written together
    a_one_page_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INIT) |-> !(cur_we && nxt_we))
        else $error("both pages written in one cycle");

    // fade writes back to the cell it read in its read phase
    a_fade_same_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FADE && r_ph == FD_WR) |-> (cur_waddr == $past(cur_raddr, 2)))
        else $error("fade write-back address differs from its read");

    // a new result appears only from the output load state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> ($past(r_state) == S_OUT))
        else $error("result raised outside the output load");

endmodule
